// ----- src/clr_pkg.sv -----
// Package for the clipped line rasterizer: field widths, codes and reset values.
// No dependencies; used by the interfaces and the top level.
package clr_pkg;

   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;
   localparam int COORD_BITS_DEF    = 12;

   localparam int ADDR_BITS   = 17;
   localparam int COLOR_BITS  = 8;
   localparam int STATUS_BITS = 2;

   localparam int CLIP_X_BITS = 9;
   localparam int CLIP_Y_BITS = 8;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int REG_IDX_BITS  = 2;

   localparam logic [REG_IDX_BITS-1:0] REG_CLIP_LEFT   = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_CLIP_TOP    = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_CLIP_WIDTH  = 2'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_CLIP_HEIGHT = 2'd3;

   localparam logic [CLIP_X_BITS-1:0] CLIP_LEFT_RST   = 9'd0;
   localparam logic [CLIP_Y_BITS-1:0] CLIP_TOP_RST    = 8'd0;
   localparam logic [CLIP_X_BITS-1:0] CLIP_WIDTH_RST  = 9'd320;
   localparam logic [CLIP_Y_BITS-1:0] CLIP_HEIGHT_RST = 8'd240;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_WRITTEN    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_CLIPPED    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OFF_SCREEN = 2'd2;

endpackage

// ----- src/clr_if.sv -----
// Valid/ready channel interfaces for line commands and pixel writes.
// Depends on clr_pkg.
interface clr_req_if
   import clr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [COORD_BITS-1:0] x_begin;
   logic [COORD_BITS-1:0] y_begin;
   logic [COORD_BITS-1:0] x_finish;
   logic [COORD_BITS-1:0] y_finish;
   logic [COLOR_BITS-1:0] pen_color;

   modport source (output valid, operation, x_begin, y_begin, x_finish, y_finish,
                   pen_color, input ready);
   modport sink (input valid, operation, x_begin, y_begin, x_finish, y_finish,
                 pen_color, output ready);
endinterface

interface clr_rsp_if
   import clr_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [ADDR_BITS-1:0]   pixel_address;
   logic [COLOR_BITS-1:0]  pixel_value;
   logic [STATUS_BITS-1:0] pixel_status;
   logic                   line_done;

   modport source (output valid, pixel_address, pixel_value, pixel_status, line_done,
                   input ready);
   modport sink (input valid, pixel_address, pixel_value, pixel_status, line_done,
                 output ready);
endinterface

// ----- src/clipped_line_rasterizer_top.sv -----
// Top level of the clipped Bresenham line rasterizer with its clip registers.
// Depends on clr_pkg and the channel interfaces in clr_if.sv.

// The block takes one beat per clock. A start beat loads the endpoints and color
// and gives no pixel; each step beat of a line gives one pixel write, computed in
// a single pass from the position and error registers into the result register,
// which also advances the Bresenham step. Ready drops only while the result
// register holds a beat that has not been taken. The user must write the clip
// registers, at APB byte addresses 0, 4, 8 and 12, only while idle (not enforced).
module clipped_line_rasterizer_top
   import clr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int COORD_BITS    = COORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   clr_req_if.sink                  req_ch,
   clr_rsp_if.source                rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int EW         = COORD_BITS + 2;
   localparam int ROW_STRIDE = SCREEN_WIDTH + 1;

   logic [CLIP_X_BITS-1:0] clip_left_ff, clip_left_in;
   logic [CLIP_Y_BITS-1:0] clip_top_ff, clip_top_in;
   logic [CLIP_X_BITS-1:0] clip_width_ff, clip_width_in;
   logic [CLIP_Y_BITS-1:0] clip_height_ff, clip_height_in;

   logic [COORD_BITS-1:0]        pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]        pos_y_ff, pos_y_in;
   logic [COORD_BITS-1:0]        target_x_ff, target_x_in;
   logic [COORD_BITS-1:0]        target_y_ff, target_y_in;
   logic [COORD_BITS-1:0]        delta_x_ff, delta_x_in;
   logic signed [COORD_BITS:0]   neg_delta_y_ff, neg_delta_y_in;
   logic                         step_x_neg_ff, step_x_neg_in;
   logic                         step_y_neg_ff, step_y_neg_in;
   logic signed [EW-1:0]         error_ff, error_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;
   logic                         drawing_ff, drawing_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [COLOR_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic                    in_ready, in_accept, is_start, is_step, rsp_load;
   logic                    csr_write;
   logic [REG_IDX_BITS-1:0] csr_idx;
   logic                    x_fwd, y_fwd, done, off_screen, clipped, move_x, move_y;
   logic [COORD_BITS-1:0]   dx_abs, dy_abs;
   logic signed [EW:0]      twice, ndy_ext, dx_ext;
   logic [31:0]             lin_addr;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      clip_left_in   = clip_left_ff;
      clip_top_in    = clip_top_ff;
      clip_width_in  = clip_width_ff;
      clip_height_in = clip_height_ff;
      if (csr_write) begin
         case (csr_idx)
            REG_CLIP_LEFT:   clip_left_in   = csr_pwdata[CLIP_X_BITS-1:0];
            REG_CLIP_TOP:    clip_top_in    = csr_pwdata[CLIP_Y_BITS-1:0];
            REG_CLIP_WIDTH:  clip_width_in  = csr_pwdata[CLIP_X_BITS-1:0];
            REG_CLIP_HEIGHT: clip_height_in = csr_pwdata[CLIP_Y_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CLIP_LEFT:   csr_prdata = CSR_DATA_BITS'(clip_left_ff);
         REG_CLIP_TOP:    csr_prdata = CSR_DATA_BITS'(clip_top_ff);
         REG_CLIP_WIDTH:  csr_prdata = CSR_DATA_BITS'(clip_width_ff);
         REG_CLIP_HEIGHT: csr_prdata = CSR_DATA_BITS'(clip_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // handshake
   assign in_ready     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = in_ready;
   assign in_accept    = req_ch.valid && in_ready;
   assign is_start     = in_accept && (req_ch.operation == OP_START);
   assign is_step      = in_accept && (req_ch.operation == OP_STEP);
   assign rsp_load     = is_step && drawing_ff;

   // setup of a new line
   assign x_fwd  = req_ch.x_begin < req_ch.x_finish;
   assign y_fwd  = req_ch.y_begin < req_ch.y_finish;
   assign dx_abs = x_fwd ? (req_ch.x_finish - req_ch.x_begin)
                         : (req_ch.x_begin - req_ch.x_finish);
   assign dy_abs = y_fwd ? (req_ch.y_finish - req_ch.y_begin)
                         : (req_ch.y_begin - req_ch.y_finish);

   // current point
   assign done       = (pos_x_ff == target_x_ff) && (pos_y_ff == target_y_ff);
   assign off_screen = (32'(pos_x_ff) >= 32'(SCREEN_WIDTH)) ||
                       (32'(pos_y_ff) >= 32'(SCREEN_HEIGHT));
   assign clipped    = (32'(pos_x_ff) < 32'(clip_left_ff)) ||
                       (32'(pos_y_ff) < 32'(clip_top_ff)) ||
                       (32'(pos_x_ff) >= 32'(clip_left_ff) + 32'(clip_width_ff)) ||
                       (32'(pos_y_ff) >= 32'(clip_top_ff) + 32'(clip_height_ff));
   assign lin_addr   = 32'(pos_y_ff) * 32'(ROW_STRIDE) + 32'(pos_x_ff);

   // Bresenham step decision
   assign twice   = {error_ff, 1'b0};
   assign ndy_ext = (EW+1)'(neg_delta_y_ff);
   assign dx_ext  = (EW+1)'($signed({1'b0, delta_x_ff}));
   assign move_x  = twice >= ndy_ext;
   assign move_y  = twice <= dx_ext;

   always_comb begin
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      target_x_in    = target_x_ff;
      target_y_in    = target_y_ff;
      delta_x_in     = delta_x_ff;
      neg_delta_y_in = neg_delta_y_ff;
      step_x_neg_in  = step_x_neg_ff;
      step_y_neg_in  = step_y_neg_ff;
      error_in       = error_ff;
      color_in       = color_ff;
      drawing_in     = drawing_ff;
      if (is_start) begin
         pos_x_in       = req_ch.x_begin;
         pos_y_in       = req_ch.y_begin;
         target_x_in    = req_ch.x_finish;
         target_y_in    = req_ch.y_finish;
         delta_x_in     = dx_abs;
         neg_delta_y_in = -$signed({1'b0, dy_abs});
         step_x_neg_in  = !x_fwd;
         step_y_neg_in  = !y_fwd;
         error_in       = EW'($signed({1'b0, dx_abs})) - EW'($signed({1'b0, dy_abs}));
         color_in       = req_ch.pen_color;
         drawing_in     = 1'b1;
      end else if (rsp_load) begin
         if (done) begin
            drawing_in = 1'b0;
         end else begin
            error_in = error_ff
                     + (move_x ? EW'(neg_delta_y_ff) : EW'(0))
                     + (move_y ? EW'($signed({1'b0, delta_x_ff})) : EW'(0));
            if (move_x) begin
               pos_x_in = step_x_neg_ff ? pos_x_ff - 1'b1 : pos_x_ff + 1'b1;
            end
            if (move_y) begin
               pos_y_in = step_y_neg_ff ? pos_y_ff - 1'b1 : pos_y_ff + 1'b1;
            end
         end
      end
   end

   // result register
   always_comb begin
      rsp_addr_in   = rsp_addr_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_done_in   = done;
         rsp_addr_in   = '0;
         rsp_value_in  = '0;
         if (off_screen) begin
            rsp_status_in = STATUS_OFF_SCREEN;
         end else if (clipped) begin
            rsp_status_in = STATUS_CLIPPED;
         end else begin
            rsp_status_in = STATUS_WRITTEN;
            rsp_addr_in   = lin_addr[ADDR_BITS-1:0];
            rsp_value_in  = color_ff;
         end
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pixel_address = rsp_addr_ff;
   assign rsp_ch.pixel_value   = rsp_value_ff;
   assign rsp_ch.pixel_status  = rsp_status_ff;
   assign rsp_ch.line_done     = rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= CLIP_LEFT_RST;
         clip_top_ff    <= CLIP_TOP_RST;
         clip_width_ff  <= CLIP_WIDTH_RST;
         clip_height_ff <= CLIP_HEIGHT_RST;
         drawing_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         clip_left_ff   <= clip_left_in;
         clip_top_ff    <= clip_top_in;
         clip_width_ff  <= clip_width_in;
         clip_height_ff <= clip_height_in;
         drawing_ff     <= drawing_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff       <= pos_x_in;
      pos_y_ff       <= pos_y_in;
      target_x_ff    <= target_x_in;
      target_y_ff    <= target_y_in;
      delta_x_ff     <= delta_x_in;
      neg_delta_y_ff <= neg_delta_y_in;
      step_x_neg_ff  <= step_x_neg_in;
      step_y_neg_ff  <= step_y_neg_in;
      error_ff       <= error_in;
      color_ff       <= color_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_done_ff    <= rsp_done_in;
   end

   a_no_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      (in_accept && !rsp_load) |=> !rsp_valid_ff)
      else $error("beat without a pixel left a result pending");

   a_start_loads_line: assert property (@(posedge clock) disable iff (reset)
      is_start |=> drawing_ff)
      else $error("start beat did not begin a line");

   a_done_ends_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && done) |=> (!drawing_ff && rsp_valid_ff && rsp_done_ff))
      else $error("final pixel did not end the line");

   a_unwritten_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_WRITTEN)
         |-> (rsp_addr_ff == '0 && rsp_value_ff == '0))
      else $error("dropped pixel carries address or color");

endmodule

// ----- verif/clr_line_checker.sv -----
// Pixel checker for the clipped line rasterizer: tracks clip registers off the APB port,
// predicts each pixel beat of a Bresenham walk and compares it with the block's output.
// Depends on clr_pkg and the clr_req_if / clr_rsp_if interfaces.
module clr_line_checker
   import clr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   clr_req_if                       req_ch,
   clr_rsp_if                       rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       mismatch_count,
   output int                       pixels_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W = COORD_BITS_DEF;

   typedef struct packed {
      logic [ADDR_BITS-1:0]   address;
      logic [COLOR_BITS-1:0]  value;
      logic [STATUS_BITS-1:0] status;
      logic                   done;
   } pixel_type;

   pixel_type pixel_queue[$];

   logic [CLIP_X_BITS-1:0] win_left, win_width;
   logic [CLIP_Y_BITS-1:0] win_top, win_height;

   logic [COORD_W-1:0]    pen_x, pen_y, end_x, end_y, span_x;
   logic signed [COORD_W:0]   neg_span_y;
   logic signed [COORD_W+1:0] walk_err;
   logic                  x_down, y_down, drawing;
   logic [COLOR_BITS-1:0] ink;
   int                    miss_total = 0;

   assign mismatch_count = miss_total;

   function automatic void clear_model();
      win_left   = CLIP_LEFT_RST;
      win_top    = CLIP_TOP_RST;
      win_width  = CLIP_WIDTH_RST;
      win_height = CLIP_HEIGHT_RST;
      pen_x = '0; pen_y = '0; end_x = '0; end_y = '0; span_x = '0;
      neg_span_y = '0; walk_err = '0;
      x_down = 1'b0; y_down = 1'b0; drawing = 1'b0;
      ink = '0;
   endfunction

   function automatic void write_window(logic [REG_IDX_BITS-1:0] idx,
                                        logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         REG_CLIP_LEFT:   win_left   = value[CLIP_X_BITS-1:0];
         REG_CLIP_TOP:    win_top    = value[CLIP_Y_BITS-1:0];
         REG_CLIP_WIDTH:  win_width  = value[CLIP_X_BITS-1:0];
         REG_CLIP_HEIGHT: win_height = value[CLIP_Y_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic void load_line(logic [COORD_W-1:0] xb, logic [COORD_W-1:0] yb,
                                     logic [COORD_W-1:0] xf, logic [COORD_W-1:0] yf,
                                     logic [COLOR_BITS-1:0] color);
      int dy;
      pen_x  = xb;
      pen_y  = yb;
      end_x  = xf;
      end_y  = yf;
      x_down = !(xb < xf);
      y_down = !(yb < yf);
      span_x = (xb < xf) ? xf - xb : xb - xf;
      dy = (yb < yf) ? int'(yf) - int'(yb) : int'(yb) - int'(yf);
      neg_span_y = (COORD_W+1)'(-dy);
      walk_err   = (COORD_W+2)'(int'(span_x) - dy);
      ink     = color;
      drawing = 1'b1;
   endfunction

   function automatic pixel_type trace_pixel();
      pixel_type px;
      int x_i, y_i, e, twice, dx, ndy;
      px  = '0;
      x_i = pen_x;
      y_i = pen_y;
      px.done = (pen_x == end_x) && (pen_y == end_y);
      if (x_i >= SCREEN_WIDTH_DEF || y_i >= SCREEN_HEIGHT_DEF) begin
         px.status = STATUS_OFF_SCREEN;
      end else if (x_i < int'(win_left) || y_i < int'(win_top) ||
                   x_i >= int'(win_left) + int'(win_width) ||
                   y_i >= int'(win_top) + int'(win_height)) begin
         px.status = STATUS_CLIPPED;
      end else begin
         px.status  = STATUS_WRITTEN;
         px.address = ADDR_BITS'(y_i * (SCREEN_WIDTH_DEF + 1) + x_i);
         px.value   = ink;
      end
      if (px.done) begin
         drawing = 1'b0;
      end else begin
         e     = walk_err;
         dx    = span_x;
         ndy   = neg_span_y;
         twice = 2 * e;
         if (twice >= ndy) begin
            e     = e + ndy;
            pen_x = x_down ? pen_x - 1'b1 : pen_x + 1'b1;
         end
         if (twice <= dx) begin
            e     = e + dx;
            pen_y = y_down ? pen_y - 1'b1 : pen_y + 1'b1;
         end
         walk_err = (COORD_W+2)'(e);
      end
      return px;
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         miss_total++;
         if (miss_total <= 10)
            $display("pixel mismatch on %s: expected %0d, got %0d", field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      pixel_type want;
      if (reset) begin
         clear_model();
         pixel_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_window(csr_paddr[3:2], csr_pwdata);
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.operation == OP_START)
               load_line(req_ch.x_begin, req_ch.y_begin, req_ch.x_finish, req_ch.y_finish,
                         req_ch.pen_color);
            else if (drawing)
               pixel_queue.push_back(trace_pixel());
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pixel_queue.size() == 0) begin
               miss_total++;
               if (miss_total <= 10)
                  $display("unexpected pixel beat: address %0d status %0d",
                           rsp_ch.pixel_address, rsp_ch.pixel_status);
            end else begin
               want = pixel_queue.pop_front();
               check_field("pixel_address", want.address, rsp_ch.pixel_address);
               check_field("pixel_value", want.value, rsp_ch.pixel_value);
               check_field("pixel_status", want.status, rsp_ch.pixel_status);
               check_field("line_done", want.done, rsp_ch.line_done);
            end
         end
      end
      pixels_owed <= pixel_queue.size();
   end

endmodule

// ----- verif/tb_clipped_line_rasterizer_top.sv -----
// Testbench top for the clipped line rasterizer: drives line commands, clip register
// writes and pixel back-pressure, and reports the verdict from clr_line_checker.
// Depends on clr_pkg, clr_if.sv, clipped_line_rasterizer_top and clr_line_checker.
module tb_clipped_line_rasterizer_top
   import clr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W = COORD_BITS_DEF;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int   pixel_mismatches, pixels_owed;
   int   items_sent    = 0;
   int   hold_requests = 0;
   logic full_speed    = 1'b0;

   clr_req_if req_ch ();
   clr_rsp_if rsp_ch ();

   clipped_line_rasterizer_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   clr_line_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (pixel_mismatches),
      .pixels_owed    (pixels_owed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   // pixel side back-pressure
   initial begin : pixel_sink
      int stall_left;
      int holds_served;
      stall_left   = 0;
      holds_served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            stall_left   = 200;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (full_speed || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            stall_left = idle_cycles();
         end
      end
   end

   task automatic send_beat(input logic op, input logic [COORD_W-1:0] xb,
                            input logic [COORD_W-1:0] yb, input logic [COORD_W-1:0] xf,
                            input logic [COORD_W-1:0] yf, input logic [COLOR_BITS-1:0] color);
      int gap;
      gap = full_speed ? 0 : idle_cycles();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.x_begin   <= xb;
      req_ch.y_begin   <= yb;
      req_ch.x_finish  <= xf;
      req_ch.y_finish  <= yf;
      req_ch.pen_color <= color;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic step_beat();
      send_beat(OP_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), COLOR_BITS'($urandom));
   endtask

   task automatic start_beat(input int xb, input int yb, input int xf, input int yf,
                             input int color);
      send_beat(OP_START, COORD_W'(xb), COORD_W'(yb), COORD_W'(xf), COORD_W'(yf),
                COLOR_BITS'(color));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pixels_owed != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx, input int value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_window(input int left, input int top, input int width, input int height);
      wait_drained();
      csr_write(REG_CLIP_LEFT, left);
      csr_write(REG_CLIP_TOP, top);
      csr_write(REG_CLIP_WIDTH, width);
      csr_write(REG_CLIP_HEIGHT, height);
   endtask

   function automatic int pick_coord(int limit);
      if ($urandom_range(0, 6) == 0) return $urandom_range(0, 4095);
      return $urandom_range(0, limit);
   endfunction

   function automatic int near_coord(int v);
      int n;
      n = v + int'($urandom_range(0, 80)) - 40;
      if (n < 0) n = 0;
      if (n > 4095) n = 4095;
      return n;
   endfunction

   task automatic random_line();
      int kind, xb, yb, xf, yf, dx, dy, steps, r;
      kind = $urandom_range(0, 99);
      full_speed = ($urandom_range(0, 5) == 0);
      if (kind < 8) begin
         send_beat(1'($urandom), COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom), COLOR_BITS'($urandom));
      end else if (kind < 18) begin
         start_beat($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 255));
         repeat ($urandom_range(1, 30)) step_beat();
      end else begin
         xb = pick_coord(340);
         yb = pick_coord(260);
         xf = near_coord(xb);
         yf = near_coord(yb);
         start_beat(xb, yb, xf, yf, $urandom_range(0, 255));
         dx = (xf > xb) ? xf - xb : xb - xf;
         dy = (yf > yb) ? yf - yb : yb - yf;
         steps = ((dx > dy) ? dx : dy) + 1;
         r = $urandom_range(0, 9);
         if (r == 0) steps = $urandom_range(1, steps);
         else if (r == 1) steps += $urandom_range(1, 2);
         repeat (steps) step_beat();
      end
   endtask

   initial begin : stimulus
      int budget;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_START;
      req_ch.x_begin   = '0;
      req_ch.y_begin   = '0;
      req_ch.x_finish  = '0;
      req_ch.y_finish  = '0;
      req_ch.pen_color = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // step while idle, single-point lines at the screen corners and far off screen
      step_beat();
      start_beat(0, 0, 0, 0, 8'hFF);
      step_beat();
      start_beat(319, 239, 319, 239, 8'h00);
      step_beat();
      start_beat(4095, 4095, 4095, 4095, 8'h81);
      step_beat();
      // short line, then a step after it has ended
      start_beat(0, 0, 3, 1, 8'h5A);
      repeat (5) step_beat();
      // abandon a line midway, then walk upward
      start_beat(10, 10, 20, 20, 8'h11);
      repeat (2) step_beat();
      start_beat(5, 7, 5, 5, 8'hA5);
      repeat (3) step_beat();
      // run off the right edge
      start_beat(318, 5, 322, 4, 8'h3C);
      repeat (5) step_beat();
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_window(0, 0, 0, 0);
            1: set_window(319, 239, 320, 240);
            2: set_window(100, 60, 120, 100);
            6: set_window(0, 0, 320, 0);
            7: set_window(CLIP_LEFT_RST, CLIP_TOP_RST, CLIP_WIDTH_RST, CLIP_HEIGHT_RST);
            default: set_window($urandom_range(0, 319), $urandom_range(0, 239),
                                $urandom_range(0, 320), $urandom_range(0, 240));
         endcase
         if (phase == 2) hold_requests++;
         budget = items_sent + 205;
         while (items_sent < budget) begin
            random_line();
            if (phase == 4 && items_sent >= budget - 110 && items_sent < budget - 100)
               wait_drained();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (pixel_mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- files.f -----
src/clr_pkg.sv
src/clr_if.sv
src/clipped_line_rasterizer_top.sv
verif/clr_line_checker.sv
verif/tb_clipped_line_rasterizer_top.sv
